### src/assert_macros.svh
// Assertion macros used by the response checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mbrc_pkg.sv
// Types, codes, CRC helper and frame check for the Modbus RTU response checker.
package mbrc_pkg;

	localparam logic [1:0] ACT_ARM  = 2'd0;
	localparam logic [1:0] ACT_BYTE = 2'd1;
	localparam logic [1:0] ACT_GAP  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EXCEPTION = 3'd1;
	localparam logic [2:0] ST_SHORT     = 3'd2;
	localparam logic [2:0] ST_LENGTH    = 3'd3;
	localparam logic [2:0] ST_CRC       = 3'd4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  MIN_FRAME = 8'd7;
	localparam logic [8:0]  LEN_OVERHEAD = 9'd5;
	localparam logic [7:0]  EXC_FLAG = 8'h80;
	localparam logic [7:0]  MAX_LEN = 8'd255;

	localparam logic [2:0] REG_ADDRESS = 3'd0;
	localparam logic [2:0] REG_COUNT   = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  exception_code;
		logic [7:0]  frame_length;
		logic [15:0] first_register;
		logic [15:0] second_register;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic result_t finish_frame(input logic [7:0] len, input logic [7:0] size,
			input logic [15:0] crc, input logic [15:0] last, input logic [31:0] data);
		result_t r;
		r = '0;
		r.frame_length = len;
		if (len < MIN_FRAME)
			r.status = ST_SHORT;
		else if ({1'b0, len} != ({1'b0, size} + LEN_OVERHEAD))
			r.status = ST_LENGTH;
		else if (crc != {last[7:0], last[15:8]})
			r.status = ST_CRC;
		else begin
			r.status = ST_OK;
			r.first_register = data[31:16];
			if (len >= 8'd9)
				r.second_register = data[15:0];
		end
		return r;
	endfunction

endpackage

### src/modbus_rtu_response_checker.sv
// Top level: Modbus RTU response checker with APB register port.
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item): one word per UART event,
//   action arm, data byte or gap. An arm starts a receive; bytes before the
//   expected slave address are skipped, then the frame is collected until a
//   gap, the length limit of twice the register count plus 5 (at most 255)
//   or an exception reply's third byte.
//   result channel (result_valid/result_ready/result): one word per finished
//   frame with status, exception code, length and the first two registers.
//   Words that finish nothing give no result.
// Timing: a word sits in the input register after its accepting edge and its
//   result is loaded into the output register once that register is free or
//   being read. Throughput: one word per cycle while no result waits on
//   result_ready, set by the combinational state update (byte-wide CRC step)
//   between the two registers.
// Reset: no receive is active, registers go to address 0 and count 1.
// Stall: while a result waits on result_ready, the word in the input
//   register waits and byte_ready drops once the input register is full.
// APB: address 0 expected_address, address 4 register count; pready is high.
module modbus_rtu_response_checker
	import mbrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  byte_item_t  byte_item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	typedef enum logic [1:0] {
		PH_DONE    = 2'd0,
		PH_HUNT    = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	logic [7:0]  address_q;
	logic [6:0]  count_q;

	logic        item_valid_s1;
	byte_item_t  item_s1;

	phase_t      phase_q, phase_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [7:0]  func_q, func_n;
	logic [7:0]  size_q, size_n;
	logic [15:0] crc_q, crc_n;
	logic [15:0] last_q, last_n;
	logic [31:0] data_q, data_n;

	logic        result_valid_q;
	result_t     result_q;

	logic        advance;
	logic        emit;
	result_t     res;
	logic [8:0]  limit_raw;
	logic [7:0]  limit;

	// Register port
	assign pready = 1'b1;
	always_comb begin
		if (paddr == REG_ADDRESS)
			prdata = {24'd0, address_q};
		else if (paddr == REG_COUNT)
			prdata = {25'd0, count_q};
		else
			prdata = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= 8'd0;
			count_q   <= 7'd1;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2])
				count_q <= pwdata[6:0];
			else
				address_q <= pwdata[7:0];
		end
	end

	assign limit_raw = {1'b0, count_q, 1'b0} + LEN_OVERHEAD;
	assign limit = limit_raw[8] ? MAX_LEN : limit_raw[7:0];

	assign advance = !result_valid_q || result_ready;
	assign byte_ready = !item_valid_s1 || advance;

	// Frame state update for the word in the input register
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		func_n  = func_q;
		size_n  = size_q;
		crc_n   = crc_q;
		last_n  = last_q;
		data_n  = data_q;
		emit    = 1'b0;
		res     = '0;
		case (item_s1.action)
			ACT_ARM: begin
				phase_n = PH_HUNT;
				cnt_n   = 8'd0;
				func_n  = 8'd0;
				size_n  = 8'd0;
				crc_n   = CRC_INIT;
				last_n  = 16'd0;
				data_n  = 32'd0;
			end
			ACT_BYTE: begin
				if (phase_q != PH_DONE &&
						(phase_q == PH_COLLECT || item_s1.data_byte == address_q)) begin
					phase_n = PH_COLLECT;
					if (cnt_q >= 8'd2)
						crc_n = crc_byte(crc_q, last_q[15:8]);
					last_n = {last_q[7:0], item_s1.data_byte};
					case (cnt_q)
						8'd1: func_n = item_s1.data_byte;
						8'd2: size_n = item_s1.data_byte;
						8'd3: data_n[31:24] = item_s1.data_byte;
						8'd4: data_n[23:16] = item_s1.data_byte;
						8'd5: data_n[15:8]  = item_s1.data_byte;
						8'd6: data_n[7:0]   = item_s1.data_byte;
						default: ;
					endcase
					cnt_n = cnt_q + 8'd1;
					if (cnt_n == 8'd3 && (func_q & EXC_FLAG) != 8'd0) begin
						emit = 1'b1;
						res.status = ST_EXCEPTION;
						res.exception_code = item_s1.data_byte;
						res.frame_length = 8'd3;
						phase_n = PH_DONE;
					end else if (cnt_n >= limit) begin
						emit = 1'b1;
						res = finish_frame(cnt_n, size_n, crc_n, last_n, data_n);
						phase_n = PH_DONE;
					end
				end
			end
			ACT_GAP: begin
				if (phase_q != PH_DONE) begin
					emit = 1'b1;
					res = finish_frame(cnt_q, size_q, crc_q, last_q, data_q);
					phase_n = PH_DONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
			phase_q        <= PH_DONE;
			cnt_q          <= 8'd0;
			func_q         <= 8'd0;
			size_q         <= 8'd0;
			crc_q          <= CRC_INIT;
			last_q         <= 16'd0;
			data_q         <= 32'd0;
		end else begin
			if (byte_ready) begin
				item_valid_s1 <= byte_valid;
			end
			if (advance) begin
				result_valid_q <= item_valid_s1 && emit;
				if (item_valid_s1) begin
					phase_q <= phase_n;
					cnt_q   <= cnt_n;
					func_q  <= func_n;
					size_q  <= size_n;
					crc_q   <= crc_n;
					last_q  <= last_n;
					data_q  <= data_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			item_s1 <= byte_item;
		if (advance && item_valid_s1 && emit)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_exc_len, result_valid && result.status == ST_EXCEPTION,
		result.frame_length == 8'd3, "exception result with wrong length")
	`ASSERT_IMPLIES(a_err_regs, result_valid && result.status != ST_OK,
		result.first_register == 16'd0 && result.second_register == 16'd0,
		"registers reported on a failed frame")
	`ASSERT_IMPLIES(a_exc_code, result_valid && result.status != ST_EXCEPTION,
		result.exception_code == 8'd0, "exception code on a non-exception result")
	`ASSERT_NEXT(a_hold_s1, item_valid_s1 && !advance, item_valid_s1,
		"input register lost a word while stalled")

endmodule
